// ===== hw/rtl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants for the best-fit heap allocator
// Transaction payload structs, status and opcode codes, and offset widths.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 4096;
  // Byte offsets inside the heap walk; wide enough for an offset plus a size.
  localparam int unsigned OFF_W = 17;
  localparam int unsigned HB_W  = 13;
  localparam int unsigned WORD_W = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_NULL     = 3'd3;
  localparam logic [2:0] ST_MISALIGN = 3'd4;
  localparam logic [2:0] ST_OUTSIDE  = 3'd5;
  localparam logic [2:0] ST_DBL_FREE = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [12:0] request_size;
    logic [11:0] free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] block_address;
  } rsp_t;

endpackage

// ===== hw/rtl/best_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top: best-fit heap manager over a word memory
// Allocate and free transactions walk block headers with one sequencer and
// one single-port-read, single-port-write word memory.
// ----------------------------------------------------------------------------
// Allocate walks every block header, then updates headers, footers and the
//   next block's p-bit; free walks headers up to the target, then merges free
//   neighbours and rewrites header and footer. Each memory read is registered.
// Throughput: one transaction at a time; ready is low from accept until the
//   result is taken.
// Reset: control clears, heap_bytes returns to its default, and a format pass
//   (S_FMT0, S_FMT1, S_FMT2) writes header, footer and end mark before ready
//   rises. A heap_bytes write runs the same format pass.
module best_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [12:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bfha_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfha_pkg::rsp_t  out_data_o
);

  localparam int unsigned OW     = bfha_pkg::OFF_W;
  localparam int unsigned WW     = bfha_pkg::WORD_W;
  localparam int unsigned NWORDS = HEAP_BYTES / 4;
  localparam int unsigned AW     = $clog2(NWORDS);
  localparam int unsigned TOP    = (HEAP_BYTES / 8) * 8;
  localparam int unsigned HB_RST = (TOP < 4096) ? TOP : 4096;

  localparam logic [4:0] S_FMT0  = 5'd0;
  localparam logic [4:0] S_FMT1  = 5'd1;
  localparam logic [4:0] S_FMT2  = 5'd2;
  localparam logic [4:0] S_IDLE  = 5'd3;
  localparam logic [4:0] S_ARD   = 5'd4;
  localparam logic [4:0] S_ACHK  = 5'd5;
  localparam logic [4:0] S_ASPL  = 5'd6;
  localparam logic [4:0] S_ASP2  = 5'd7;
  localparam logic [4:0] S_ASP3  = 5'd8;
  localparam logic [4:0] S_ANRD  = 5'd9;
  localparam logic [4:0] S_ANWR  = 5'd10;
  localparam logic [4:0] S_FRD   = 5'd11;
  localparam logic [4:0] S_FCHK  = 5'd12;
  localparam logic [4:0] S_FHDR  = 5'd13;
  localparam logic [4:0] S_FNRD  = 5'd14;
  localparam logic [4:0] S_FNWR  = 5'd15;
  localparam logic [4:0] S_FPRD  = 5'd16;
  localparam logic [4:0] S_FPCHK = 5'd17;
  localparam logic [4:0] S_FPST  = 5'd18;
  localparam logic [4:0] S_FCOAL = 5'd19;
  localparam logic [4:0] S_FW1   = 5'd20;
  localparam logic [4:0] S_FW2   = 5'd21;

  localparam logic [WW-1:0] SZ_MASK = 16'hFFFC;

  // Sequencer registers
  logic [4:0]    state_q, state_d;
  logic [OW-1:0] hb_q, hb_d;
  logic [OW-1:0] cur_q, cur_d;
  logic [OW-1:0] fit_q, fit_d;
  logic [OW-1:0] fitsz_q, fitsz_d;
  logic [WW-1:0] fithdr_q, fithdr_d;
  logic [OW-1:0] need_q, need_d;
  logic [OW-1:0] hdr_q, hdr_d;
  logic [OW-1:0] sz_q, sz_d;
  logic          pbit_q, pbit_d;
  logic [OW-1:0] start_q, start_d;
  logic [OW-1:0] nxt_q, nxt_d;
  logic [WW-1:0] nxtw_q, nxtw_d;
  logic          nxtok_q, nxtok_d;
  logic          out_valid_q, out_valid_d;
  bfha_pkg::rsp_t out_q, out_d;

  // Memory port
  logic [WW-1:0] mem [NWORDS];
  logic          mem_we, mem_re;
  logic [OW-1:0] mem_woff, mem_roff;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] mem_rd_q;
  logic          rd_ok_q;
  logic [WW-1:0] rdv;

  logic [OW-1:0] end_w, rem_w, cfg_v;
  logic [WW-1:0] w_sz;
  logic          in_acc;

  assign end_w  = hb_q - OW'(4);
  assign rem_w  = fitsz_q - need_q;
  assign rdv    = rd_ok_q ? mem_rd_q : '0;
  assign w_sz   = rdv & SZ_MASK;
  assign in_acc = in_valid_i && in_ready_o;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Clamp a heap_bytes write: round down to 8, then into [64, TOP].
  always_comb begin
    cfg_v = OW'({cfg_wdata_i[12:3], 3'b000});
    if (cfg_v < OW'(64)) begin
      cfg_v = OW'(64);
    end
    if (cfg_v > OW'(TOP)) begin
      cfg_v = OW'(TOP);
    end
  end

  always_comb begin
    state_d     = state_q;
    hb_d        = hb_q;
    cur_d       = cur_q;
    fit_d       = fit_q;
    fitsz_d     = fitsz_q;
    fithdr_d    = fithdr_q;
    need_d      = need_q;
    hdr_d       = hdr_q;
    sz_d        = sz_q;
    pbit_d      = pbit_q;
    start_d     = start_q;
    nxt_d       = nxt_q;
    nxtw_d      = nxtw_q;
    nxtok_d     = nxtok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_woff    = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_roff    = '0;

    // Drop the result once the sink takes the transaction.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Format: one free block, its footer, then the end mark.
      S_FMT0: begin
        mem_we    = 1'b1;
        mem_woff  = OW'(4);
        mem_wdata = WW'(hb_q - OW'(8)) | WW'(2);
        state_d   = S_FMT1;
      end
      S_FMT1: begin
        mem_we    = 1'b1;
        mem_woff  = hb_q - OW'(8);
        mem_wdata = WW'(hb_q - OW'(8));
        state_d   = S_FMT2;
      end
      S_FMT2: begin
        mem_we    = 1'b1;
        mem_woff  = end_w;
        mem_wdata = WW'(1);
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          out_d.block_address = '0;
          cur_d = OW'(4);
          fit_d = '0;
          hdr_d = OW'(in_data_i.free_address) - OW'(4);
          if (in_data_i.opcode == bfha_pkg::OP_ALLOC) begin
            need_d = (OW'(in_data_i.request_size) + OW'(11)) & ~OW'(7);
            if (in_data_i.request_size == '0) begin
              out_d.status = bfha_pkg::ST_BAD_SIZE;
              out_valid_d  = 1'b1;
            end else begin
              state_d = S_ARD;
            end
          end else begin
            if (in_data_i.free_address == '0) begin
              out_d.status = bfha_pkg::ST_NULL;
              out_valid_d  = 1'b1;
            end else if (in_data_i.free_address[2:0] != 3'b000) begin
              out_d.status = bfha_pkg::ST_MISALIGN;
              out_valid_d  = 1'b1;
            end else begin
              state_d = S_FRD;
            end
          end
        end
      end
      // Best-fit walk: read a header, then compare it.
      S_ARD: begin
        if (cur_q < end_w) begin
          mem_re   = 1'b1;
          mem_roff = cur_q;
          state_d  = S_ACHK;
        end else if (fit_q == '0) begin
          out_d.status = bfha_pkg::ST_NO_FIT;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_ASPL;
        end
      end
      S_ACHK: begin
        if (w_sz == '0) begin
          cur_d = end_w;
        end else begin
          if (!rdv[0] && OW'(w_sz) >= need_q &&
              (fit_q == '0 || OW'(w_sz) < fitsz_q)) begin
            fit_d    = cur_q;
            fitsz_d  = OW'(w_sz);
            fithdr_d = rdv;
          end
          cur_d = cur_q + OW'(w_sz);
        end
        state_d = S_ARD;
      end
      S_ASPL: begin
        mem_we = 1'b1;
        if (rem_w >= OW'(12)) begin
          mem_woff  = fit_q + need_q;
          mem_wdata = WW'(rem_w) | WW'(2);
          sz_d      = need_q;
          state_d   = S_ASP2;
        end else begin
          mem_woff  = fit_q;
          mem_wdata = fithdr_q | WW'(1);
          sz_d      = fitsz_q;
          state_d   = S_ANRD;
        end
      end
      S_ASP2: begin
        mem_we    = 1'b1;
        mem_woff  = fit_q + fitsz_q - OW'(4);
        mem_wdata = WW'(rem_w);
        state_d   = S_ASP3;
      end
      S_ASP3: begin
        mem_we    = 1'b1;
        mem_woff  = fit_q;
        mem_wdata = WW'(need_q) | WW'(1) | (fithdr_q & WW'(2));
        state_d   = S_ANRD;
      end
      // Set the p-bit of the block after the new allocation.
      S_ANRD: begin
        if (fit_q + sz_q < end_w) begin
          mem_re   = 1'b1;
          mem_roff = fit_q + sz_q;
          state_d  = S_ANWR;
        end else begin
          out_d.status        = bfha_pkg::ST_OK;
          out_d.block_address = 12'(fit_q + OW'(4));
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_ANWR: begin
        mem_we              = 1'b1;
        mem_woff            = fit_q + sz_q;
        mem_wdata           = rdv | WW'(2);
        out_d.status        = bfha_pkg::ST_OK;
        out_d.block_address = 12'(fit_q + OW'(4));
        out_valid_d         = 1'b1;
        state_d             = S_IDLE;
      end
      // Free: walk from the heap start to validate the pointer.
      S_FRD: begin
        if (cur_q < end_w && cur_q <= hdr_q) begin
          mem_re   = 1'b1;
          mem_roff = cur_q;
          state_d  = (cur_q == hdr_q) ? S_FHDR : S_FCHK;
        end else begin
          out_d.status = bfha_pkg::ST_OUTSIDE;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FCHK: begin
        if (w_sz == '0) begin
          out_d.status = bfha_pkg::ST_OUTSIDE;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cur_d   = cur_q + OW'(w_sz);
          state_d = S_FRD;
        end
      end
      S_FHDR: begin
        if (!rdv[0]) begin
          out_d.status = bfha_pkg::ST_DBL_FREE;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          sz_d    = OW'(w_sz);
          pbit_d  = rdv[1];
          start_d = hdr_q;
          nxt_d   = hdr_q + OW'(w_sz);
          state_d = S_FNRD;
        end
      end
      S_FNRD: begin
        if (nxt_q < end_w) begin
          mem_re   = 1'b1;
          mem_roff = nxt_q;
          nxtok_d  = 1'b1;
          state_d  = S_FNWR;
        end else begin
          nxtok_d = 1'b0;
          state_d = S_FPRD;
        end
      end
      S_FNWR: begin
        mem_we    = 1'b1;
        mem_woff  = nxt_q;
        mem_wdata = rdv & ~WW'(2);
        nxtw_d    = rdv & ~WW'(2);
        state_d   = S_FPRD;
      end
      // Merge with a free predecessor found through its footer.
      S_FPRD: begin
        if (!pbit_q && hdr_q >= OW'(8)) begin
          mem_re   = 1'b1;
          mem_roff = hdr_q - OW'(4);
          state_d  = S_FPCHK;
        end else begin
          state_d = S_FCOAL;
        end
      end
      S_FPCHK: begin
        if (w_sz != '0 && OW'(w_sz) <= hdr_q - OW'(4)) begin
          start_d  = hdr_q - OW'(w_sz);
          sz_d     = sz_q + OW'(w_sz);
          mem_re   = 1'b1;
          mem_roff = hdr_q - OW'(w_sz);
          state_d  = S_FPST;
        end else begin
          state_d = S_FCOAL;
        end
      end
      S_FPST: begin
        pbit_d  = rdv[1];
        state_d = S_FCOAL;
      end
      S_FCOAL: begin
        if (nxtok_q && !nxtw_q[0]) begin
          sz_d = sz_q + OW'(nxtw_q & SZ_MASK);
        end
        state_d = S_FW1;
      end
      S_FW1: begin
        mem_we    = 1'b1;
        mem_woff  = start_q;
        mem_wdata = WW'(sz_q) | {{(WW-2){1'b0}}, pbit_q, 1'b0};
        state_d   = S_FW2;
      end
      S_FW2: begin
        mem_we       = 1'b1;
        mem_woff     = start_q + sz_q - OW'(4);
        mem_wdata    = WW'(sz_q);
        out_d.status = bfha_pkg::ST_OK;
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A heap_bytes write reformats the heap.
    if (cfg_we_i) begin
      hb_d    = cfg_v;
      state_d = S_FMT0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FMT0;
      hb_q        <= OW'(HB_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hb_q        <= hb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    fit_q    <= fit_d;
    fitsz_q  <= fitsz_d;
    fithdr_q <= fithdr_d;
    need_q   <= need_d;
    hdr_q    <= hdr_d;
    sz_q     <= sz_d;
    pbit_q   <= pbit_d;
    start_q  <= start_d;
    nxt_q    <= nxt_d;
    nxtw_q   <= nxtw_d;
    nxtok_q  <= nxtok_d;
    out_q    <= out_d;
  end

  // Heap word memory; offsets past the memory read as zero and drop writes.
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_woff[OW-1:2] < (OW-2)'(NWORDS)) begin
      mem[mem_woff[AW+1:2]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_ok_q  <= mem_roff[OW-1:2] < (OW-2)'(NWORDS);
      mem_rd_q <= mem[mem_roff[AW+1:2]];
    end
  end

  a_ready_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q && !mem_we)
    else $error("ready raised while busy");

  a_result_after_accept_or_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != S_FMT0 && $past(state_q) != S_FMT1)
    else $error("result raised during format");

  a_alloc_ok_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_q.status == bfha_pkg::ST_OK && out_q.block_address != '0
      |-> out_q.block_address[2:0] == 3'b000)
    else $error("allocated payload not 8-byte aligned");

endmodule

// ===== tb/tb_best_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_best_fit_heap_allocator_top: self-checking bench for the heap allocator
// Drives allocate and free transactions over several heap sizes, predicts each
// response with a shadow heap, and compares responses in order, field by field.
// ----------------------------------------------------------------------------
module tb_best_fit_heap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NWORDS     = bfha_pkg::HEAP_BYTES_DEF / 4;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned HOLD_LONG  = 400;

  // Shadow heap: same word image as the block, updated at every accepted
  // request, with the expected responses kept in order.
  class heap_shadow;
    logic [15:0]    words [NWORDS];
    int unsigned    heap_size;
    bfha_pkg::rsp_t expected_rsp [$];
    int unsigned    live_blocks [$];
    int unsigned    freed_blocks [$];
    int             errors;

    function int unsigned rd(int unsigned off);
      return (off >> 2) < NWORDS ? words[off >> 2] : 0;
    endfunction

    function void wr(int unsigned off, int unsigned v);
      if ((off >> 2) < NWORDS) words[off >> 2] = v[15:0];
    endfunction

    function void format_heap();
      int unsigned total;
      total = heap_size - 8;
      foreach (words[i]) words[i] = '0;
      wr(4, total | 2);
      wr(total, total);
      wr(heap_size - 4, 1);
      live_blocks.delete();
      freed_blocks.delete();
    endfunction

    function void configure(logic [12:0] value);
      int unsigned v;
      v = value & ~32'd7;
      if (v < 64) v = 64;
      if (v > (bfha_pkg::HEAP_BYTES_DEF & ~32'd7)) v = bfha_pkg::HEAP_BYTES_DEF & ~32'd7;
      heap_size = v;
      format_heap();
    endfunction

    function logic [2:0] allocate(int unsigned req, output int unsigned addr);
      int unsigned last, need, cur, fit, fitsz, w, sz, hdr, rem, nxt;
      last = heap_size - 4;
      cur = 4; fit = 0; fitsz = 0;
      addr = 0;
      if (req == 0) return bfha_pkg::ST_BAD_SIZE;
      need = (req + 11) & ~32'd7;
      while (cur < last) begin
        w = rd(cur);
        sz = w & 16'hFFFC;
        if (sz == 0) break;
        if (!w[0] && sz >= need && (fit == 0 || sz < fitsz)) begin
          fit = cur;
          fitsz = sz;
        end
        cur += sz;
      end
      if (fit == 0) return bfha_pkg::ST_NO_FIT;
      hdr = rd(fit);
      rem = fitsz - need;
      if (rem >= 12) begin
        wr(fit + need, rem | 2);
        wr(fit + need + rem - 4, rem);
        wr(fit, need | 1 | (hdr & 2));
        sz = need;
      end else begin
        wr(fit, hdr | 1);
        sz = fitsz;
      end
      nxt = fit + sz;
      if (nxt < last) wr(nxt, rd(nxt) | 2);
      addr = fit + 4;
      return bfha_pkg::ST_OK;
    endfunction

    function logic [2:0] release_block(int unsigned addr);
      int unsigned last, hdr, cur, s, w, sz, start, pbit, nxt, pf;
      bit found;
      last = heap_size - 4;
      cur = 4;
      found = 0;
      if (addr == 0) return bfha_pkg::ST_NULL;
      if (addr & 7) return bfha_pkg::ST_MISALIGN;
      hdr = addr - 4;
      while (cur < last && cur <= hdr) begin
        s = rd(cur) & 16'hFFFC;
        if (cur == hdr) begin
          found = 1;
          break;
        end
        if (s == 0) break;
        cur += s;
      end
      if (!found) return bfha_pkg::ST_OUTSIDE;
      w = rd(hdr);
      if (!w[0]) return bfha_pkg::ST_DBL_FREE;
      sz = w & 16'hFFFC;
      pbit = w & 2;
      start = hdr;
      nxt = hdr + sz;
      if (nxt < last) wr(nxt, rd(nxt) & ~32'd2);
      if (pbit == 0 && hdr >= 8) begin
        pf = rd(hdr - 4) & 16'hFFFC;
        if (pf != 0 && pf <= hdr - 4) begin
          start = hdr - pf;
          pbit = rd(start) & 2;
          sz += pf;
        end
      end
      if (nxt < last && (rd(nxt) & 1) == 0) sz += rd(nxt) & 16'hFFFC;
      wr(start, sz | pbit);
      wr(start + sz - 4, sz);
      return bfha_pkg::ST_OK;
    endfunction

    function void note_request(bfha_pkg::req_t r);
      bfha_pkg::rsp_t e;
      int unsigned    a;
      a = 0;
      if (r.opcode == bfha_pkg::OP_ALLOC) begin
        e.status = allocate(r.request_size, a);
        if (e.status == bfha_pkg::ST_OK) live_blocks.push_back(a);
      end else begin
        e.status = release_block(r.free_address);
        if (e.status == bfha_pkg::ST_OK) begin
          foreach (live_blocks[i]) begin
            if (live_blocks[i] == r.free_address) begin
              live_blocks.delete(i);
              break;
            end
          end
          freed_blocks.push_back(r.free_address);
          if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
        end
      end
      e.block_address = a[11:0];
      expected_rsp.push_back(e);
    endfunction

    function void check_response(bfha_pkg::rsp_t got);
      bfha_pkg::rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response status=%0d addr=%0d",
                 $time, got.status, got.block_address);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.block_address !== e.block_address) begin
        $display("%0t: block_address expected %0d actual %0d",
                 $time, e.block_address, got.block_address);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [12:0]    cfg_wdata_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  bfha_pkg::req_t in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  bfha_pkg::rsp_t out_data_o;

  heap_shadow shadow;
  bit         quiet;      // no idling on either side
  bit         hold_req;   // ask the receiver for one long hold-off

  best_fit_heap_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one transaction and hold it until accepted; valid stays high on exit
  // unless a random idle drops it, so back-to-back transactions need no reassignment.
  task automatic send(bfha_pkg::req_t r);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_request(r);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic alloc(int unsigned n);
    bfha_pkg::req_t r;
    r = '0;
    r.opcode = bfha_pkg::OP_ALLOC;
    r.request_size = n[12:0];
    r.free_address = 12'($urandom);   // ignored field, keep it noisy
    send(r);
  endtask

  task automatic free_at(int unsigned a);
    bfha_pkg::req_t r;
    r = '0;
    r.opcode = bfha_pkg::OP_FREE;
    r.free_address = a[11:0];
    r.request_size = 13'($urandom);
    send(r);
  endtask

  // Drain outstanding responses, let the block settle, then rewrite the heap size.
  task automatic write_heap_size(logic [12:0] v);
    in_valid_i <= 1'b0;
    while (shadow.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.configure(v);
  endtask

  // Mostly well-formed traffic: allocate, free live blocks, a few bad requests.
  task automatic random_traffic(int unsigned n);
    int unsigned pick, idx;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) alloc($urandom_range(1, shadow.heap_size));
        else alloc($urandom_range(1, 96));
      end else if (pick < 88 && shadow.live_blocks.size() != 0) begin
        idx = $urandom_range(shadow.live_blocks.size() - 1);
        free_at(shadow.live_blocks[idx]);
      end else if (pick < 92 && shadow.freed_blocks.size() != 0) begin
        free_at(shadow.freed_blocks[$urandom_range(shadow.freed_blocks.size() - 1)]);
      end else if (pick < 95) begin
        free_at($urandom_range(4095));
      end else if (pick < 97) begin
        free_at($urandom_range(511) * 8);
      end else if (pick < 98) begin
        alloc(0);
      end else begin
        alloc($urandom_range(4097, 8191));
      end
    end
  endtask

  // Receiver: check every response, stall in random bursts, one long hold-off.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) shadow.check_response(out_data_o);
      if (hold_req) begin
        hold_req = 0;
        hold = HOLD_LONG;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (quiet || $urandom_range(3) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        hold = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb_best_fit_heap_allocator_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned a;
    shadow = new();
    shadow.configure(13'(bfha_pkg::HEAP_BYTES_DEF));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: error codes, field extremes, split, coalesce, double free.
    alloc(0);
    alloc(8191);
    alloc(4096);
    free_at(0);
    free_at(12'hFFF);
    free_at(3);
    free_at(12'hFF8);
    free_at(16);            // aligned but not a block header
    alloc(1);
    alloc(8);
    alloc(9);
    alloc(100);
    a = shadow.live_blocks[1];
    free_at(a);
    free_at(a);             // already free
    free_at(shadow.live_blocks[0]);   // merges with the free block after it
    free_at(shadow.live_blocks[1]);   // merges with the free block after it
    alloc(4096 - 12);       // heap size minus leading pad word, header and end mark
    free_at(8);
    alloc(4000);            // leaves at least 12 bytes: splits
    free_at(8);

    // Smallest heap, then a sweep of sizes including clamped writes.
    write_heap_size(13'd64);
    alloc(56); alloc(49); alloc(1); alloc(1); alloc(1);
    random_traffic(80);
    write_heap_size(13'd5);      // raised to the minimum
    random_traffic(60);
    write_heap_size(13'd203);    // rounded down to a multiple of eight
    random_traffic(100);
    write_heap_size(13'h1FFF);   // lowered to the full heap
    random_traffic(120);
    write_heap_size(13'($urandom_range(64, 4095)));
    random_traffic(100);

    // Long receiver hold-off while the sender keeps offering.
    write_heap_size(13'd4096);
    hold_req = 1;
    random_traffic(100);

    // Last stretch without idling.
    write_heap_size(13'($urandom_range(512, 2048)));
    quiet = 1;
    random_traffic(120);

    in_valid_i <= 1'b0;
    while (shadow.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("tb_best_fit_heap_allocator_top: clean");
    end else begin
      $display("tb_best_fit_heap_allocator_top: errors");
    end
    $finish;
  end

endmodule
